// File: rtl/mm_pkg.sv
// ----------------------------------------------------------------------------
// mm_pkg
// Shared types, sizes and helpers for the matrix multiply core.
// ----------------------------------------------------------------------------
package mm_pkg;

	localparam int MAX_DIM    = 8;
	localparam int ELEM_WIDTH = 16;

	localparam int DEPTH     = MAX_DIM * MAX_DIM;
	localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int DV_W      = $clog2(MAX_DIM + 1);
	localparam int CA_W      = $clog2(DEPTH + 1);
	localparam int CNT_W     = $clog2(2 * DEPTH + 1);
	localparam int PROD_W    = 2 * ELEM_WIDTH;
	localparam int ACC_W     = 40;
	localparam int IDX_W     = 3;
	localparam int CFG_W     = 4;
	localparam int CFG_IDX_W = 2;
	localparam int QD        = 2;
	localparam int QP_W      = 1;
	localparam int QC_W      = 2;

	localparam logic [CFG_IDX_W-1:0] REG_ROWS_A = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INNER  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COLS_B = 2'd2;

	localparam logic [CFG_W-1:0] RST_ROWS_A = 4'd2;
	localparam logic [CFG_W-1:0] RST_INNER  = 4'd3;
	localparam logic [CFG_W-1:0] RST_COLS_B = 4'd2;

	typedef enum logic {
		ST_LOAD,
		ST_RUN
	} back_state_t;

	typedef struct packed {
		logic                  sel_b;
		logic [AW-1:0]         addr;
		logic [ELEM_WIDTH-1:0] elem;
		logic                  last;
	} q_item_t;

	typedef struct packed {
		logic [DV_W-1:0] ra;
		logic [DV_W-1:0] ni;
		logic [DV_W-1:0] cb;
		logic [CA_W-1:0] count_a;
		logic [CA_W-1:0] count_b;
	} dims_t;

	typedef struct packed {
		logic             first_k;
		logic             last_k;
		logic             last_entry;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
	} mac_tag_t;

	function automatic logic [DV_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
		logic [DV_W-1:0] d;
		if (v == '0)
			d = DV_W'(1);
		else if (int'(v) > MAX_DIM)
			d = DV_W'(MAX_DIM);
		else
			d = DV_W'(v);
		return d;
	endfunction

endpackage

// File: rtl/mm_ram.sv
// ----------------------------------------------------------------------------
// mm_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module mm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/mm_front.sv
// ----------------------------------------------------------------------------
// mm_front
// Dimension registers and element loader: tags each beat with its store and
// address and marks the final element of B.
// ----------------------------------------------------------------------------
module mm_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [mm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mm_pkg::CFG_W-1:0]      cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [mm_pkg::ELEM_WIDTH-1:0] element,
	input  logic                          q_full,
	output logic                          q_push,
	output mm_pkg::q_item_t               q_item,
	output mm_pkg::dims_t                 dims
);
	import mm_pkg::*;

	logic [CFG_W-1:0] rows_a_q;
	logic [CFG_W-1:0] inner_q;
	logic [CFG_W-1:0] cols_b_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_a_w;
	logic [CNT_W-1:0] total_w;
	logic             sel_b;
	logic             last_elem;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q <= RST_ROWS_A;
			inner_q  <= RST_INNER;
			cols_b_q <= RST_COLS_B;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROWS_A: rows_a_q <= cfg_data;
				REG_INNER:  inner_q  <= cfg_data;
				REG_COLS_B: cols_b_q <= cfg_data;
				default:    ;
			endcase
		end
	end

	always_comb begin
		dims.ra      = eff_dim(rows_a_q);
		dims.ni      = eff_dim(inner_q);
		dims.cb      = eff_dim(cols_b_q);
		dims.count_a = CA_W'(dims.ra) * CA_W'(dims.ni);
		dims.count_b = CA_W'(dims.ni) * CA_W'(dims.cb);
	end

	assign count_a_w = CNT_W'(dims.count_a);
	assign total_w   = count_a_w + CNT_W'(dims.count_b);
	assign sel_b     = (count_q >= count_a_w);
	assign last_elem = (count_q == total_w - CNT_W'(1));

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;

	always_comb begin
		q_item.sel_b = sel_b;
		q_item.addr  = sel_b ? AW'(count_q - count_a_w) : AW'(count_q);
		q_item.elem  = element;
		q_item.last  = last_elem;
	end

	// a write to any listed register restarts the load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_we && (cfg_index == REG_ROWS_A || cfg_index == REG_INNER ||
				cfg_index == REG_COLS_B)) begin
			count_q <= '0;
		end else if (q_push) begin
			count_q <= last_elem ? '0 : count_q + CNT_W'(1);
		end
	end

endmodule

// File: rtl/mm_queue.sv
// ----------------------------------------------------------------------------
// mm_queue
// Two-entry queue of classified element beats between loader and MAC engine.
// ----------------------------------------------------------------------------
module mm_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  mm_pkg::q_item_t item_in,
	output logic            full,
	output logic            valid,
	output mm_pkg::q_item_t item_out,
	input  logic            pop
);
	import mm_pkg::*;

	q_item_t         entries_q [QD];
	logic [QP_W-1:0] wr_ptr_q;
	logic [QP_W-1:0] rd_ptr_q;
	logic [QC_W-1:0] cnt_q;

	assign full     = (cnt_q == QC_W'(QD));
	assign valid    = (cnt_q != '0);
	assign item_out = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entries_q[wr_ptr_q] <= item_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QP_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QP_W'(1);
			if (push && !pop)
				cnt_q <= cnt_q + QC_W'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - QC_W'(1);
		end
	end

endmodule

// File: rtl/mm_back.sv
// ----------------------------------------------------------------------------
// mm_back
// Store writer and single MAC engine: walks row, column and inner index,
// accumulates each product entry and holds it in the output register.
// ----------------------------------------------------------------------------
module mm_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_valid,
	input  mm_pkg::q_item_t              q_item,
	output logic                         q_pop,
	input  mm_pkg::dims_t                dims,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [mm_pkg::ACC_W-1:0] product,
	output logic [mm_pkg::IDX_W-1:0]     out_row,
	output logic [mm_pkg::IDX_W-1:0]     out_col,
	output logic                         last
);
	import mm_pkg::*;

	back_state_t state_q, state_d;

	logic [DV_W-1:0] r_q, c_q, k_q;
	logic [AW-1:0]   a_addr_q, a_row_q, b_addr_q;
	logic            last_k, last_c, last_r;
	logic            issue;
	logic            start;
	logic            adv;

	logic [ELEM_WIDTH-1:0] a_rd, b_rd;
	mac_tag_t              tag_w, tag_s1, tag_s2;
	logic                  v_s1, v_s2;
	logic signed [PROD_W-1:0] product_s2;
	logic signed [ACC_W-1:0]  acc_q, acc_base, sum_w;
	logic                     load_out;

	logic                    out_valid_q;
	logic signed [ACC_W-1:0] product_q;
	logic [IDX_W-1:0]        row_q, col_q;
	logic                    last_q;

	assign last_k = (k_q == dims.ni - DV_W'(1));
	assign last_c = (c_q == dims.cb - DV_W'(1));
	assign last_r = (r_q == dims.ra - DV_W'(1));

	// the pipe freezes only when a finished entry meets a held output register that is stalled
	assign adv      = !(v_s2 && tag_s2.last_k && out_valid_q && out_stall);
	assign issue    = (state_q == ST_RUN) && adv;
	assign load_out = adv && v_s2 && tag_s2.last_k;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_LOAD;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		start   = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				q_pop = q_valid;
				if (q_valid && q_item.last) begin
					start   = 1'b1;
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (issue && last_k && last_c && last_r)
					state_d = ST_LOAD;
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q      <= '0;
			c_q      <= '0;
			k_q      <= '0;
			a_addr_q <= '0;
			a_row_q  <= '0;
			b_addr_q <= '0;
		end else if (start) begin
			r_q      <= '0;
			c_q      <= '0;
			k_q      <= '0;
			a_addr_q <= '0;
			a_row_q  <= '0;
			b_addr_q <= '0;
		end else if (issue) begin
			if (!last_k) begin
				k_q      <= k_q + DV_W'(1);
				a_addr_q <= a_addr_q + AW'(1);
				b_addr_q <= b_addr_q + AW'(dims.cb);
			end else begin
				k_q <= '0;
				if (!last_c) begin
					c_q      <= c_q + DV_W'(1);
					a_addr_q <= a_row_q;
					b_addr_q <= AW'(c_q) + AW'(1);
				end else begin
					c_q      <= '0;
					b_addr_q <= '0;
					r_q      <= r_q + DV_W'(1);
					a_row_q  <= a_row_q + AW'(dims.ni);
					a_addr_q <= a_row_q + AW'(dims.ni);
				end
			end
		end
	end

	mm_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_store_a (
		.clk   (clk),
		.we    (q_pop && !q_item.sel_b),
		.waddr (q_item.addr),
		.wdata (q_item.elem),
		.re    (adv),
		.raddr (a_addr_q),
		.rdata (a_rd)
	);

	mm_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_store_b (
		.clk   (clk),
		.we    (q_pop && q_item.sel_b),
		.waddr (q_item.addr),
		.wdata (q_item.elem),
		.re    (adv),
		.raddr (b_addr_q),
		.rdata (b_rd)
	);

	always_comb begin
		tag_w.first_k    = (k_q == '0);
		tag_w.last_k     = last_k;
		tag_w.last_entry = last_r && last_c;
		tag_w.row        = IDX_W'(r_q);
		tag_w.col        = IDX_W'(c_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s1     <= tag_w;
			tag_s2     <= tag_s1;
			product_s2 <= $signed(a_rd) * $signed(b_rd);
		end
	end

	assign acc_base = tag_s2.first_k ? '0 : acc_q;
	assign sum_w    = acc_base + ACC_W'(product_s2);

	always_ff @(posedge clk) begin
		if (adv && v_s2)
			acc_q <= sum_w;
		if (load_out) begin
			product_q <= sum_w;
			row_q     <= tag_s2.row;
			col_q     <= tag_s2.col;
			last_q    <= tag_s2.last_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_out)
			out_valid_q <= 1'b1;
		else if (out_valid_q && !out_stall)
			out_valid_q <= 1'b0;
	end

	assign out_valid = out_valid_q;
	assign product   = product_q;
	assign out_row   = row_q;
	assign out_col   = col_q;
	assign last      = last_q;

`ifndef NO_ASSERTIONS
	a_addr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> CA_W'(a_addr_q) < dims.count_a)
		else $error("store a address beyond loaded matrix");

	b_addr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> CA_W'(b_addr_q) < dims.count_b)
		else $error("store b address beyond loaded matrix");

	no_pop_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> !q_pop)
		else $error("store written while products are being issued");

	no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> !out_valid_q || !out_stall)
		else $error("held result overwritten");

	final_is_complete: assert property (@(posedge clk) disable iff (!arst_n)
		load_out && tag_s2.last_entry |=> state_q == ST_LOAD || $past(state_d) == ST_RUN)
		else $error("final entry delivered while issue still running");
`endif

endmodule

// File: rtl/matrix_multiply_core.sv
// ----------------------------------------------------------------------------
// matrix_multiply_core
// Streaming integer matrix multiplier: loads A then B element by element and
// delivers every entry of A times B in row-major order.
// ----------------------------------------------------------------------------
// Elements are taken one per cycle, while the queue is not full, into a
// two-beat queue and written to the A and B stores one per cycle. Once the
// final element of B reaches the store, the single multiply-accumulate unit
// issues one product term per cycle unless it is frozen; while the unit is
// busy the input stalls as soon as the queue holds two beats. A stall on the
// result side freezes the unit once a finished entry waits behind the held
// result. Dimension values of zero act as one and values above eight act as
// eight; any dimension write restarts the load. No clearing pass is run after
// reset.
// ----------------------------------------------------------------------------
module matrix_multiply_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [mm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mm_pkg::CFG_W-1:0]         cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic signed [mm_pkg::ELEM_WIDTH-1:0] element,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [mm_pkg::ACC_W-1:0]  product,
	output logic [mm_pkg::IDX_W-1:0]         out_row,
	output logic [mm_pkg::IDX_W-1:0]         out_col,
	output logic                             last
);
	import mm_pkg::*;

	logic    q_full, q_push, q_valid, q_pop;
	q_item_t q_in, q_out;
	dims_t   dims;

	mm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.element   (element),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_item    (q_in),
		.dims      (dims)
	);

	mm_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.item_in  (q_in),
		.full     (q_full),
		.valid    (q_valid),
		.item_out (q_out),
		.pop      (q_pop)
	);

	mm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_out),
		.q_pop     (q_pop),
		.dims      (dims),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.product   (product),
		.out_row   (out_row),
		.out_col   (out_col),
		.last      (last)
	);

endmodule
